>>> hw/rtl/sm3_pkg.sv
// Shared types, constants and round functions for the SM3 digest block.
package sm3_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } t_out_word;

    // front-end command to the compression engine
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } t_blk_cmd;

    localparam int QueueDepth = 2;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenLimit = 6'd55;
    localparam logic [31:0] TLow = 32'h79cc4519;
    localparam logic [31:0] THigh = 32'h7a879d8a;
    localparam logic [255:0] Iv = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

>>> hw/rtl/sm3_front.sv
// Front end: collects bytes into blocks, pads the last one, issues block commands.
module sm3_front import sm3_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_word i_in,
    input  logic     i_valid,
    output logic     o_ready,
    output t_blk_cmd o_cmd,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready
);
    localparam logic [1:0] S_BYTES = 2'd0;
    localparam logic [1:0] S_PAD2  = 2'd1;

    logic [1:0]   r_state, n_state;
    // byte k sits at bits 511-8k, each lane read at its fixed place
    logic [511:0] r_buf;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [511:0] w_blk, w_pad, w_len;
    logic         w_acc, w_full, w_two;
    logic [5:0]   w_fill_nb;
    logic [63:0]  w_bits_nb;
    logic         w_has;

    assign w_acc = i_valid && o_ready;
    assign w_has = i_in.has_byte;
    // byte count after this word's byte
    assign w_fill_nb = r_fill + {5'd0, w_has};
    assign w_bits_nb = r_bits + (w_has ? 64'd8 : 64'd0);
    assign w_full = w_has && (r_fill == 6'd63);

    // current buffer with this word's byte merged
    always_comb begin
        for (int k = 0; k < 64; k++) begin
            w_blk[511-8*k -: 8] = (w_has && (6'(k) == r_fill)) ? i_in.data_byte
                                                               : r_buf[511-8*k -: 8];
        end
    end

    // padded block: 0x80 at fill, zeros above, length at the tail if room
    assign w_two = !w_full && (w_fill_nb > LenLimit);
    always_comb begin
        for (int k = 0; k < 64; k++) begin
            if (6'(k) < w_fill_nb) w_pad[511-8*k -: 8] = w_blk[511-8*k -: 8];
            else if (6'(k) == w_fill_nb) w_pad[511-8*k -: 8] = PadByte;
            else w_pad[511-8*k -: 8] = 8'd0;
        end
        if (!w_two) w_pad[63:0] = w_bits_nb;
    end
    assign w_len = {448'd0, r_bits};

    assign o_ready = (r_state == S_BYTES) && i_cmd_ready;

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd = '{block: w_pad, final_blk: 1'b0};
        n_state = r_state;
        unique case (r_state)
            S_PAD2: begin
                o_cmd_valid = 1'b1;
                // full block then 0x80 block, or padded block then length block
                o_cmd.block = w_len;
                o_cmd.block[511:504] = (r_fill == 6'd0) ? PadByte : 8'd0;
                o_cmd.final_blk = 1'b1;
                if (i_cmd_ready) n_state = S_BYTES;
            end
            default: begin
                if (i_valid && (w_full || i_in.last)) begin
                    o_cmd_valid = i_cmd_ready;
                    if (w_full) begin
                        o_cmd.block = w_blk;
                        o_cmd.final_blk = 1'b0;
                    end else begin
                        o_cmd.final_blk = !w_two;
                    end
                    if (i_in.last && (w_full || w_two)) n_state = S_PAD2;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BYTES;
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                if (w_has) r_buf[511-8*r_fill -: 8] <= i_in.data_byte;
                if (i_in.last && (w_full || w_two)) begin
                    r_fill <= w_full ? 6'd0 : 6'd1;  // marks which second block
                    r_bits <= w_bits_nb;
                end else if (i_in.last) begin
                    r_fill <= '0;
                    r_bits <= '0;
                end else begin
                    r_fill <= w_fill_nb;
                    r_bits <= w_bits_nb;
                end
            end else if (r_state == S_PAD2 && i_cmd_ready) begin
                r_fill <= '0;
                r_bits <= '0;
            end
        end
    end
endmodule

>>> hw/rtl/sm3_queue.sv
// Small command queue between the front end and the compression engine.
module sm3_queue import sm3_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_blk_cmd i_cmd,
    input  logic     i_valid,
    output logic     o_ready,
    output t_blk_cmd o_cmd,
    output logic     o_valid,
    input  logic     i_ready
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
    t_blk_cmd        r_mem [Depth];
    logic [Aw-1:0]   r_wp, r_rp;
    logic [Aw:0]     r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == Aw'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (w_pop) r_rp <= (r_rp == Aw'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + {{Aw{1'b0}}, w_push} - {{Aw{1'b0}}, w_pop};
        end
    end
endmodule

>>> hw/rtl/sm3_engine.sv
// Compression engine: one SM3 round per cycle, then digest word output after a final block.
module sm3_engine import sm3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_blk_cmd  i_cmd,
    input  logic      i_valid,
    output logic      o_ready,
    output t_out_word o_out,
    output logic      o_valid,
    input  logic      i_ready
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FOLD = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [31:0] r_v [8];
    logic [31:0] r_r [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic        r_final;
    logic [2:0]  r_oidx;
    logic [31:0] w_wn, w_x, w_t, w_a12, w_ss1, w_ss2, w_tt1, w_tt2, w_ff, w_gg;
    logic        w_lo;

    assign o_ready = (r_state == S_IDLE);
    assign w_lo = (r_rnd < 6'd16);
    // window holds W[j..j+15]; new word W[j+16]
    assign w_x = r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15);
    assign w_wn = perm1(w_x) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    assign w_t = rotl(w_lo ? TLow : THigh, r_rnd[4:0]);
    assign w_a12 = rotl(r_r[0], 5'd12);
    assign w_ss1 = rotl(w_a12 + r_r[4] + w_t, 5'd7);
    assign w_ss2 = w_ss1 ^ w_a12;
    assign w_ff = w_lo ? (r_r[0] ^ r_r[1] ^ r_r[2])
                       : ((r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]));
    assign w_gg = w_lo ? (r_r[4] ^ r_r[5] ^ r_r[6]) : ((r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]));
    assign w_tt1 = w_ff + r_r[3] + w_ss2 + (r_w[0] ^ r_w[4]);
    assign w_tt2 = w_gg + r_r[7] + w_ss1 + r_w[0];

    assign o_valid = (r_state == S_OUT);
    assign o_out = '{digest_word: r_v[r_oidx], word_last: (r_oidx == 3'd7)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd <= '0;
            r_oidx <= '0;
            r_final <= 1'b0;
            for (int k = 0; k < 8; k++) r_v[k] <= Iv[255-32*k -: 32];
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int k = 0; k < 16; k++) r_w[k] <= i_cmd.block[511-32*k -: 32];
                        for (int k = 0; k < 8; k++) r_r[k] <= r_v[k];
                        r_final <= i_cmd.final_blk;
                        r_rnd <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                    r_w[15] <= w_wn;
                    r_r[0] <= w_tt1;
                    r_r[1] <= r_r[0];
                    r_r[2] <= rotl(r_r[1], 5'd9);
                    r_r[3] <= r_r[2];
                    r_r[4] <= perm0(w_tt2);
                    r_r[5] <= r_r[4];
                    r_r[6] <= rotl(r_r[5], 5'd19);
                    r_r[7] <= r_r[6];
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    for (int k = 0; k < 8; k++) r_v[k] <= r_v[k] ^ r_r[k];
                    r_oidx <= '0;
                    r_state <= r_final ? S_OUT : S_IDLE;
                end
                default: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            for (int k = 0; k < 8; k++) r_v[k] <= Iv[255-32*k -: 32];
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end
endmodule

>>> hw/rtl/sm3_message_digest.sv
// Top level of the SM3 message digest block.
// Usage:
//   Input channel: one byte word per handshake (data_byte, has_byte, last).
//   has_byte 0 with last 1 ends a message with no extra byte (empty message).
//   Output channel: eight 32-bit digest words, word 0 first, word_last on word 7.
// Throughput: the front end takes one word per cycle into a 64-byte buffer
//   while the queue has room and no second padding block is pending. Each
//   full block goes to a 2-entry queue; the compression engine runs 64 rounds
//   per block, one per cycle, plus load and fold, and takes no new block until
//   it has folded the last one and sent any digest. The input stalls whenever the queue is full.
// After the last word, the first digest word follows the compression of the padded
//   final block (and of a second padding block when needed), after any queued blocks.
// Reset: synchronous, active low; clears buffer count, length, queue and
//   loads the standard IV.
// Stall: when the receiver holds ready low, the digest word holds; new blocks
//   wait in the queue and the input stops once it fills.
module sm3_message_digest import sm3_pkg::*; #(
    parameter int QDepth = QueueDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  logic      i_valid,
    output logic      o_ready,
    output t_out_word o_out,
    output logic      o_valid,
    input  logic      i_ready
);
    t_blk_cmd w_fcmd, w_ecmd;
    logic     w_fvalid, w_fready, w_evalid, w_eready;

    sm3_front u_front (
        .i_clk, .i_rst_n, .i_in, .i_valid, .o_ready,
        .o_cmd(w_fcmd), .o_cmd_valid(w_fvalid), .i_cmd_ready(w_fready));

    sm3_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n, .i_cmd(w_fcmd), .i_valid(w_fvalid), .o_ready(w_fready),
        .o_cmd(w_ecmd), .o_valid(w_evalid), .i_ready(w_eready));

    sm3_engine u_engine (
        .i_clk, .i_rst_n, .i_cmd(w_ecmd), .i_valid(w_evalid), .o_ready(w_eready),
        .o_out, .o_valid, .i_ready);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out)) else $error("digest word dropped");
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fvalid && !w_fready |=> w_fvalid) else $error("block command withdrawn");
endmodule

>>> test/sm3_digest_checker.sv
// Checker for the SM3 digest block: predicts digest words and compares them.
module sm3_digest_checker import sm3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_out_word i_out,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    output int        o_fail_count,
    output int        o_pending
);

    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned fill_bytes;
    logic [63:0] bit_length;
    t_out_word   digest_q [$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = digest_q.size();

    function automatic logic [31:0] rot(logic [31:0] x, int n);
        n = n % 32;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] p_zero(logic [31:0] x);
        return x ^ rot(x, 9) ^ rot(x, 17);
    endfunction

    function automatic logic [31:0] p_one(logic [31:0] x);
        return x ^ rot(x, 15) ^ rot(x, 23);
    endfunction

    task automatic compress_block();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, tt1, tt2, wp;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 16; j < 68; j++)
            w[j] = p_one(w[j-16] ^ w[j-9] ^ rot(w[j-3], 15)) ^ rot(w[j-13], 7) ^ w[j-6];
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int j = 0; j < 64; j++) begin
            ss1 = rot(rot(a, 12) + e + rot(j < 16 ? 32'h79cc4519 : 32'h7a879d8a, j), 7);
            ss2 = ss1 ^ rot(a, 12);
            wp = w[j] ^ w[j+4];
            if (j < 16) begin
                tt1 = (a ^ b ^ c) + d + ss2 + wp;
                tt2 = (e ^ f ^ g) + h + ss1 + w[j];
            end else begin
                tt1 = ((a & b) | (a & c) | (b & c)) + d + ss2 + wp;
                tt2 = ((e & f) | (~e & g)) + h + ss1 + w[j];
            end
            d = c; c = rot(b, 9); b = a; a = tt1;
            h = g; g = rot(f, 19); f = e; e = p_zero(tt2);
        end
        hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
        hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
    endtask

    task automatic restart_message();
        hash_state[0] = 32'h7380166f; hash_state[1] = 32'h4914b2b9;
        hash_state[2] = 32'h172442d7; hash_state[3] = 32'hda8a0600;
        hash_state[4] = 32'ha96f30bc; hash_state[5] = 32'h163138aa;
        hash_state[6] = 32'he38dee4d; hash_state[7] = 32'hb0fb0e4e;
        fill_bytes = 0;
        bit_length = '0;
    endtask

    task automatic absorb_word(t_in_word w);
        t_out_word r;
        if (w.has_byte) begin
            msg_block[fill_bytes] = w.data_byte;
            bit_length += 64'd8;
            fill_bytes++;
            if (fill_bytes == 64) begin
                compress_block();
                fill_bytes = 0;
            end
        end
        if (!w.last) return;
        msg_block[fill_bytes] = 8'h80;
        for (int i = fill_bytes + 1; i < 64; i++) msg_block[i] = '0;
        if (fill_bytes > 55) begin
            compress_block();
            for (int i = 0; i < 64; i++) msg_block[i] = '0;
        end
        for (int i = 0; i < 8; i++) msg_block[63-i] = bit_length[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_state[i];
            r.word_last   = (i == 7);
            digest_q.push_back(r);
        end
        restart_message();
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) absorb_word(i_in);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word with none expected: %h", i_out.digest_word);
                    fail_count++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (exp_w.digest_word !== i_out.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_w.digest_word, i_out.digest_word);
                        fail_count++;
                    end
                    if (exp_w.word_last !== i_out.word_last) begin
                        $error("word_last expected %b actual %b",
                               exp_w.word_last, i_out.word_last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_sm3_message_digest.sv
// Testbench top for the SM3 digest block: stimulus, idling and verdict.
module tb_sm3_message_digest import sm3_pkg::*;;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    t_in_word  in_word = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_out_word out_word;
    logic      out_valid;
    logic      out_ready = 1'b0;
    int        fail_count;
    int        pending;
    int        send_idle_pct = 26;
    int        recv_idle_pct = 71;

    sm3_message_digest dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_word), .i_valid(in_valid),
        .o_ready(in_ready), .o_out(out_word), .o_valid(out_valid), .i_ready(out_ready)
    );

    sm3_digest_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_word), .i_in_valid(in_valid),
        .i_in_ready(in_ready), .i_out(out_word), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // one word per call; holds valid until accepted, the next call replaces or drops it
    task automatic send_word(logic [7:0] b, logic hb, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_word <= '{data_byte: b, has_byte: hb, last: lst};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hff : 8'($urandom);
            if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(b, 1'b1, (i == len - 1) && mode != 3);
        end
        if (len == 0 || mode == 3) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // two-block padding, message ending on a full block, short message
    int msg_lens [] = '{56, 64, 3};

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: empty, "abc", all-zero and all-one bytes, separate end mark
        send_message(0, 2);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_message(4, 0);
        send_message(4, 1);
        send_message(3, 3);
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle_pct = 71; recv_idle_pct = 26; end
            if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            send_message(msg_lens[phase], 2);
            for (int m = 0; m < 2; m++)
                send_message($urandom_range(9) == 0 ? 0 : $urandom_range(4, 1),
                             $urandom_range(3));
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
